/* hdl/gbp_pkg.sv */
// ----------------------------------------------------------------------------
// gbp_pkg
// Shared types and constants of the gshare branch predictor.
// ----------------------------------------------------------------------------
package gbp_pkg;

   localparam int TABLE_ENTRIES = 2048;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES);
   localparam int HIST_W        = 11;
   localparam int LEN_W         = 4;
   localparam int CSR_ADDR_W    = 3;

   localparam logic [1:0]        CTR_STRONG_TAKEN = 2'd3;
   localparam logic [1:0]        CTR_STRONG_NOT   = 2'd0;
   localparam logic [LEN_W-1:0]  HIST_LEN_RESET   = LEN_W'(HIST_W);
   localparam logic [31:0]       COUNT_MAX        = 32'hFFFF_FFFF;

   // register index, taken from paddr[2]
   localparam logic CSR_IDX_HISTORY_LENGTH = 1'b0;

   typedef struct packed {
      logic [31:0] branch_address;
      logic        taken;
   } req_type;

   typedef struct packed {
      logic        predicted_taken;
      logic        correct;
      logic [31:0] correct_count;
      logic [31:0] branch_count;
   } rsp_type;

   typedef enum logic {
      ST_CLEAR,
      ST_RUN
   } state_type;

endpackage

/* hdl/gshare_branch_predictor.sv */
// ----------------------------------------------------------------------------
// gshare_branch_predictor
// A beat accepted is read from the counter memory into stage 1, then updated
// into the output register. Throughput: one beat per cycle while the response
// side does not stall, set by the synchronous read of the counter memory and a
// forward of the last write. Reset: synchronous; a clearing pass then writes every
// counter to strongly taken, during which req_ready is low. CSR writes are taken.
// ----------------------------------------------------------------------------
module gshare_branch_predictor (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  gbp_pkg::req_type                  req_data,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output gbp_pkg::rsp_type                  rsp_data,
   // APB-style CSR port
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [gbp_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [31:0]                       pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready
);
   import gbp_pkg::*;

   // ---- state -------------------------------------------------------------
   state_type             state_ff, state_in;
   logic [IDX_W-1:0]      clr_addr_ff, clr_addr_in;
   logic                  clearing;

   logic [LEN_W-1:0]      hist_len_ff;
   logic [HIST_W-1:0]     hist_ff, hist_in;
   logic [31:0]           hits_ff, hits_in;
   logic [31:0]           seen_ff, seen_in;

   // counter memory, one synchronous read and one write port
   logic [1:0]            table_mem [TABLE_ENTRIES];
   logic [1:0]            rdata_ff;

   // stage 1: beat whose counter is being read
   logic                  s1_valid_ff;
   logic [IDX_W-1:0]      s1_idx_ff;
   logic                  s1_taken_ff;
   logic                  fwd_hit_ff;
   logic [1:0]            fwd_val_ff;

   // output register
   logic                  rsp_valid_ff;
   rsp_type               rsp_data_ff;

   // ---- combinational -----------------------------------------------------
   logic                  accept;
   logic                  s1_adv;
   logic [IDX_W-1:0]      idx;
   logic [1:0]            ctr_cur;
   logic [1:0]            ctr_new;
   logic                  pred;
   logic                  ok;
   logic [LEN_W-1:0]      len_eff;
   logic [HIST_W-1:0]     hist_mask;
   logic                  mem_we;
   logic [IDX_W-1:0]      mem_waddr;
   logic [1:0]            mem_wdata;
   logic                  csr_wr;

   // ---- CSR port ----------------------------------------------------------
   assign pready = 1'b1;
   assign csr_wr = psel & penable & pwrite & pready;
   assign prdata = (paddr[2] == CSR_IDX_HISTORY_LENGTH)
                   ? {{(32-LEN_W){1'b0}}, hist_len_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_len_ff <= HIST_LEN_RESET;
      end else if (csr_wr && paddr[2] == CSR_IDX_HISTORY_LENGTH) begin
         hist_len_ff <= pwdata[LEN_W-1:0];
      end
   end

   // ---- clearing pass after reset -----------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_addr_ff <= '0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      clearing    = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            clearing    = 1'b1;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == IDX_W'(TABLE_ENTRIES - 1)) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            state_in = ST_RUN;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // ---- handshake ---------------------------------------------------------
   // stage 1 moves into the output register when that is empty or being drained
   assign s1_adv    = s1_valid_ff & (~rsp_valid_ff | rsp_ready);
   assign req_ready = (state_ff == ST_RUN) & (~s1_valid_ff | s1_adv);
   assign accept    = req_valid & req_ready;

   // ---- index and history -------------------------------------------------
   // history longer than the register acts as the full register
   assign len_eff   = (hist_len_ff > LEN_W'(HIST_W)) ? LEN_W'(HIST_W) : hist_len_ff;
   assign hist_mask = ~({HIST_W{1'b1}} << len_eff);
   assign idx       = req_data.branch_address[IDX_W-1:0] ^ IDX_W'(hist_ff);
   assign hist_in   = {hist_ff[HIST_W-2:0], req_data.taken} & hist_mask;

   // ---- counter update ----------------------------------------------------
   // the last write lands at the edge this beat was read; take it forwarded
   assign ctr_cur = fwd_hit_ff ? fwd_val_ff : rdata_ff;
   assign pred    = ctr_cur[1];
   assign ok      = (pred == s1_taken_ff);

   always_comb begin
      ctr_new = ctr_cur;
      if (s1_taken_ff) begin
         if (ctr_cur != CTR_STRONG_TAKEN) ctr_new = ctr_cur + 2'd1;
      end else begin
         if (ctr_cur != CTR_STRONG_NOT) ctr_new = ctr_cur - 2'd1;
      end
   end

   assign hits_in = (ok && hits_ff != COUNT_MAX) ? hits_ff + 32'd1 : hits_ff;
   assign seen_in = (seen_ff != COUNT_MAX) ? seen_ff + 32'd1 : seen_ff;

   // ---- memory ------------------------------------------------------------
   assign mem_we    = clearing | s1_adv;
   assign mem_waddr = clearing ? clr_addr_ff : s1_idx_ff;
   assign mem_wdata = clearing ? CTR_STRONG_TAKEN : ctr_new;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_waddr] <= mem_wdata;
      end
      if (accept) begin
         rdata_ff <= table_mem[idx];
      end
   end

   // ---- pipeline registers ------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         hist_ff      <= '0;
         hits_ff      <= '0;
         seen_ff      <= '0;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
            hist_ff     <= hist_in;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            rsp_valid_ff <= 1'b1;
            hits_ff      <= hits_in;
            seen_ff      <= seen_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_idx_ff   <= idx;
         s1_taken_ff <= req_data.taken;
         fwd_hit_ff  <= s1_adv && (idx == s1_idx_ff);
         fwd_val_ff  <= ctr_new;
      end
      if (s1_adv) begin
         rsp_data_ff.predicted_taken <= pred;
         rsp_data_ff.correct         <= ok;
         rsp_data_ff.correct_count   <= hits_in;
         rsp_data_ff.branch_count    <= seen_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* hdl/gbp_checker.sv */
// ----------------------------------------------------------------------------
// gbp_checker
// Port-level checks on the gshare branch predictor, bound to the top level.
// ----------------------------------------------------------------------------
module gbp_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_ready,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  gbp_pkg::rsp_type rsp_data,
   input  logic             pready
);
   import gbp_pkg::*;

   // clearing pass: nothing taken, nothing given right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("beat activity directly after reset");

   // stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response beat changed");

   a_count_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.correct_count <= rsp_data.branch_count
                    && rsp_data.branch_count != 32'd0)
      else $error("running counts inconsistent");

   a_correct_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_data.correct
         && rsp_data.correct_count != COUNT_MAX
      |-> rsp_data.correct_count != 32'd0)
      else $error("correct beat with zero hit count");

   a_pready: assert property (@(posedge clock) disable iff (reset) pready)
      else $error("pready low");

endmodule

bind gshare_branch_predictor gbp_checker u_gbp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data),
   .pready    (pready)
);

/* tb/sv/gshare_branch_predictor_tb.sv */
// ----------------------------------------------------------------------------
// gshare_branch_predictor_tb
// Self-checking bench for the gshare predictor. Each accepted branch beat is
// run through a local copy of the counter table and history. The expected
// response is queued and compared field by field with the response beats.
// Stimulus starts with a few hand-picked branches, then runs phases of biased,
// looping and fully random branches under several history lengths.
// ----------------------------------------------------------------------------
module gshare_branch_predictor_tb;
   import gbp_pkg::*;

   localparam int          REG_HISTORY_LENGTH = int'(CSR_IDX_HISTORY_LENGTH);
   localparam int          REG_UNMAPPED       = REG_HISTORY_LENGTH + 1;
   localparam int          MAX_REPORTS        = 10;
   localparam int          WATCHDOG_LIMIT     = 6000;   // covers the table clear
   localparam int          HOLDOFF_CYCLES     = 200;
   localparam int          DRAIN_CYCLES       = 6;      // pipeline is two deep
   localparam int          NUM_PHASES         = 10;
   localparam int          ITEMS_PER_PHASE    = 110;

   // ------------------------------------------------------------------------
   // Scoreboard: predicts each response from the branch beats seen so far.
   // ------------------------------------------------------------------------
   class branch_scoreboard;
      logic [1:0]        counters [TABLE_ENTRIES];
      logic [HIST_W-1:0] history;
      logic [31:0]       hits;
      logic [31:0]       seen;
      logic [LEN_W-1:0]  hist_len;
      rsp_type           pending_outcomes [$];
      int unsigned       mismatches;

      function new();
         foreach (counters[i]) counters[i] = CTR_STRONG_TAKEN;
         history    = '0;
         hits       = '0;
         seen       = '0;
         hist_len   = HIST_LEN_RESET;
         mismatches = 0;
      endfunction

      function void write_register(int index, logic [31:0] value);
         if (index == REG_HISTORY_LENGTH) hist_len = value[LEN_W-1:0];
      endfunction

      function void note_branch(req_type b);
         int unsigned      len;
         logic [31:0]      keep;
         logic [IDX_W-1:0] slot;
         logic [1:0]       ctr;
         rsp_type          outcome;
         // lengths above the register width behave as the full width
         len  = (hist_len > HIST_W) ? HIST_W : hist_len;
         keep = (32'd1 << len) - 32'd1;
         slot = IDX_W'(((b.branch_address % 32'(TABLE_ENTRIES)) ^ 32'(history))
                       % 32'(TABLE_ENTRIES));
         ctr  = counters[slot];
         outcome.predicted_taken = (ctr >= 2'd2);
         outcome.correct         = (outcome.predicted_taken == b.taken);
         if (b.taken) begin
            if (ctr != CTR_STRONG_TAKEN) ctr++;
         end else if (ctr != CTR_STRONG_NOT) begin
            ctr--;
         end
         counters[slot] = ctr;
         history = HIST_W'(((32'(history) << 1) | 32'(b.taken)) & keep);
         if (outcome.correct && hits != COUNT_MAX) hits++;
         if (seen != COUNT_MAX) seen++;
         outcome.correct_count = hits;
         outcome.branch_count  = seen;
         pending_outcomes.push_back(outcome);
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (pending_outcomes.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("response beat with nothing outstanding: %p", got);
            return;
         end
         want = pending_outcomes.pop_front();
         if (got.predicted_taken !== want.predicted_taken || got.correct !== want.correct ||
             got.correct_count !== want.correct_count ||
             got.branch_count !== want.branch_count) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("branch %0d: predicted_taken exp %0b got %0b, correct exp %0b got %0b,",
                        want.branch_count, want.predicted_taken, got.predicted_taken,
                        want.correct, got.correct,
                        " correct_count exp %0d got %0d, branch_count exp %0d got %0d",
                        want.correct_count, got.correct_count,
                        want.branch_count, got.branch_count);
         end
      endfunction
   endclass

   // ------------------------------------------------------------------------
   // DUT hookup
   // ------------------------------------------------------------------------
   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   req_type                 req_data;
   logic                    rsp_valid;
   logic                    rsp_ready;
   rsp_type                 rsp_data;
   logic                    psel;
   logic                    penable;
   logic                    pwrite;
   logic [CSR_ADDR_W-1:0]   paddr;
   logic [31:0]             pwdata;
   logic [31:0]             prdata;
   logic                    pready;

   gshare_branch_predictor u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   branch_scoreboard scoreboard = new();

   // stimulus-side state
   bit              steady;        // no idling on either side while set
   bit              holdoff_req;   // asks the receiver for one long stall
   int unsigned     idle_cycles;
   logic [31:0]     hot_addr [8];  // branches revisited often within a phase
   int unsigned     hot_bias [8];  // percent taken per hot branch
   logic [31:0]     loop_addr;
   int unsigned     trip;
   int unsigned     loop_step;
   logic [31:0]     phase_hist [NUM_PHASES] = '{
      32'd0, 32'd15, 32'hA5A5_A5A4, 32'd11, 32'd1,
      32'd12, 32'd7, 32'd0, 32'd11, 32'd3
   };

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // ------------------------------------------------------------------------
   // Monitor: notes request beats, checks response beats, runs the watchdog.
   // Everything is sampled on the rising edge; inputs move on the falling one.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) scoreboard.note_branch(req_data);
      if (!reset && rsp_valid && rsp_ready) scoreboard.check_result(rsp_data);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // mostly short gaps, now and then a long one
   function automatic int unsigned random_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (steady)  return 0;
      if (r < 60)  return 0;
      if (r < 92)  return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Branch mix: biased hot branches, a loop-closing branch with a fixed trip
   // count (so history correlation matters), and fully random noise.
   function automatic req_type next_branch();
      req_type     b;
      int unsigned pick;
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 40) begin
         pick             = $urandom_range(0, 7);
         b.branch_address = hot_addr[pick];
         b.taken          = ($urandom_range(0, 99) < hot_bias[pick]);
      end else if (r < 75) begin
         b.branch_address = loop_addr;
         b.taken          = (loop_step != trip - 1);
         loop_step        = (loop_step + 1) % trip;
      end else begin
         b.branch_address = $urandom;
         b.taken          = 1'($urandom_range(0, 1));
      end
      return b;
   endfunction

   // ------------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------------
   // Called at a falling edge; returns at a falling edge after the beat has
   // gone in. valid stays high when the next beat follows straight on.
   task automatic send_branch(input req_type b);
      int unsigned gap;
      req_data  = b;
      req_valid = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      gap = random_gap();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Stops sending and waits until every outstanding response has come back.
   task automatic wait_drained();
      req_valid = 1'b0;
      while (scoreboard.pending_outcomes.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Setup cycle, then access cycle; the write lands on the edge that ends it.
   task automatic csr_write(input int index, input logic [31:0] value);
      psel    = 1'b1;
      pwrite  = 1'b1;
      penable = 1'b0;
      paddr   = CSR_ADDR_W'(index * 4);
      pwdata  = value;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      scoreboard.write_register(index, value);
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   // Receiver: random back-pressure, plus one long hold-off on request.
   initial begin
      int unsigned stall_left;
      stall_left = 0;
      rsp_ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (holdoff_req) begin
            rsp_ready = 1'b0;
            repeat (HOLDOFF_CYCLES - 1) @(negedge clock);
            holdoff_req = 1'b0;
         end else if (stall_left > 0) begin
            rsp_ready = 1'b0;
            stall_left--;
         end else begin
            stall_left = random_gap();
            rsp_ready  = (stall_left == 0);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      psel        = 1'b0;
      penable     = 1'b0;
      pwrite      = 1'b0;
      paddr       = '0;
      pwdata      = '0;
      steady      = 1'b0;
      holdoff_req = 1'b0;
      idle_cycles = 0;
      loop_addr   = '0;
      trip        = 2;
      loop_step   = 0;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      // Directed: full history from reset, address extremes, both outcomes.
      // The first beats wait out the table clear behind req_ready.
      send_branch(req_type'{32'h0000_0000, 1'b0});
      send_branch(req_type'{32'h0000_0000, 1'b0});
      send_branch(req_type'{32'h0000_0000, 1'b0});
      send_branch(req_type'{32'hFFFF_FFFF, 1'b1});
      send_branch(req_type'{32'hFFFF_FFFF, 1'b1});
      send_branch(req_type'{32'h0000_07FF, 1'b1});
      send_branch(req_type'{32'h0000_0800, 1'b0});
      send_branch(req_type'{32'hAAAA_AAAA, 1'b1});
      send_branch(req_type'{32'h5555_5555, 1'b0});
      // zero history: after the first update the index is the address alone; walk one counter to both ends
      wait_drained();
      csr_write(REG_HISTORY_LENGTH, 32'd0);
      repeat (4) send_branch(req_type'{32'h0000_0000, 1'b0});
      repeat (4) send_branch(req_type'{32'h0000_0000, 1'b1});
      send_branch(req_type'{32'hFFFF_FFFF, 1'b0});
      // top of the register range behaves as eleven bits
      wait_drained();
      csr_write(REG_HISTORY_LENGTH, 32'd15);
      send_branch(req_type'{32'h1234_5678, 1'b1});
      send_branch(req_type'{32'hFFFF_F800, 1'b0});
      send_branch(req_type'{32'h0000_07FF, 1'b1});
      send_branch(req_type'{32'h8000_0000, 1'b1});

      // Random phases, one history setting each; lowering the length
      // mid-run drops the upper history bits on the next update.
      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_drained();
         csr_write(REG_HISTORY_LENGTH, phase_hist[p]);
         if (p == 2) csr_write(REG_UNMAPPED, 32'd0);   // must not touch history_length
         foreach (hot_addr[i]) begin
            hot_addr[i] = (i < 4) ? ($urandom & 32'h0000_0FFF) : $urandom;
            hot_bias[i] = (i == 7) ? 50 : ($urandom_range(0, 1) ? 95 : 5);
         end
         loop_addr = $urandom;
         trip      = $urandom_range(2, 9);
         loop_step = 0;
         steady    = (p == 6);
         for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
            // long receiver hold-off while requests keep coming: fills the pipe
            if (p == 3 && k == 30) holdoff_req = 1'b1;
            // sender pauses until every response is back
            if (p == 5 && k == 60) wait_drained();
            send_branch(next_branch());
         end
      end

      steady = 1'b0;
      wait_drained();
      if (scoreboard.mismatches == 0 && scoreboard.pending_outcomes.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

/* files.f */
hdl/gbp_pkg.sv
hdl/gshare_branch_predictor.sv
hdl/gbp_checker.sv
tb/sv/gshare_branch_predictor_tb.sv
